// File: sv/ksrr_pkg.sv
`default_nettype none
package ksrr_pkg;

  localparam int MAX_KEYS = 32;
  localparam int KEY_W = 40;
  localparam int CNT_W = 6;
  localparam int ADDR_W = $clog2(MAX_KEYS);
  localparam int OP_W = 3;
  localparam int ST_W = 3;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(20);

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
  localparam logic [OP_W-1:0] OP_NEXT = 3'd2;
  localparam logic [OP_W-1:0] OP_PREV = 3'd3;
  localparam logic [OP_W-1:0] OP_READ = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

  localparam logic [ST_W-1:0] ST_DONE = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO_KEY = 3'd1;
  localparam logic [ST_W-1:0] ST_PRESENT = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key_in;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    logic [CNT_W-1:0] current_index;
    logic [CNT_W-1:0] key_count;
    logic [CNT_W-1:0] match_index;
    logic [ST_W-1:0] status;
  } rsp_t;

endpackage
`default_nettype wire

// File: sv/key_store_round_robin_core.sv
`default_nettype none
// Clear, and next, previous or read on an empty store, answer straight from idle; other next,
// previous, read and unused codes pass through the fetch and load states; add and lookup
// scan one table entry per cycle (a zero key skips it), and lookup then fetches and loads.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset (synchronous, active high) empties the store, zeroes the pointer and sets the limit to 20.
// The result is shown for one cycle on rsp with rsp_valid; the receiver cannot stall.
module key_store_round_robin_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire ksrr_pkg::req_t   req,
  output logic                  rsp_valid,
  output ksrr_pkg::rsp_t        rsp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [5:0]       cfg_data
);
  import ksrr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FETCH = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] key_limit;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] issue_idx, issue_idx_next;
  logic pend, pend_next;
  logic [CNT_W-1:0] pend_slot, pend_slot_next;
  logic [OP_W-1:0] op_r, op_r_next;
  logic [KEY_W-1:0] key_r, key_r_next;
  logic [CNT_W-1:0] match_r, match_r_next;
  logic [ST_W-1:0] st_r, st_r_next;
  logic done_next;
  rsp_t rsp_next;

  logic [KEY_W-1:0] mem [MAX_KEYS];
  logic [KEY_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic wr_en;

  logic [CNT_W-1:0] lim;
  logic issuing, hit;
  logic [CNT_W-1:0] new_slot, new_count;

  assign cfg_ready = (state == S_IDLE) && !start;
  assign busy = (state != S_IDLE);

  always_comb begin
    if (key_limit == '0) begin
      lim = CNT_W'(1);
    end else if (key_limit > CNT_W'(MAX_KEYS)) begin
      lim = CNT_W'(MAX_KEYS);
    end else begin
      lim = key_limit;
    end
  end

  assign issuing = (issue_idx < count);
  assign hit = pend && (rd_data == key_r);

  always_comb begin
    if (count < lim) begin
      new_count = count + CNT_W'(1);
      new_slot = count + CNT_W'(1);
    end else begin
      new_count = count;
      new_slot = (ptr >= count) ? CNT_W'(1) : ptr + CNT_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next = ptr;
    issue_idx_next = issue_idx;
    pend_next = 1'b0;
    pend_slot_next = pend_slot;
    op_r_next = op_r;
    key_r_next = key_r;
    match_r_next = match_r;
    st_r_next = st_r;
    done_next = 1'b0;
    rsp_next = rsp;
    wr_en = 1'b0;
    wr_addr = ADDR_W'(new_slot - CNT_W'(1));
    rd_addr = ADDR_W'(ptr - CNT_W'(1));

    case (state)
      S_IDLE: begin
        if (start) begin
          op_r_next = req.op;
          key_r_next = req.key_in;
          match_r_next = '0;
          st_r_next = ST_DONE;
          issue_idx_next = '0;
          case (req.op)
            OP_ADD: begin
              if (req.key_in == '0) begin
                st_r_next = ST_ZERO_KEY;
                state_next = S_FETCH;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_LOOKUP: begin
              if (req.key_in == '0) begin
                st_r_next = ST_NOT_FOUND;
                state_next = S_FETCH;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_NEXT, OP_PREV, OP_READ: begin
              if (count == '0) begin
                rsp_next = '{key_out: '0, current_index: '0, key_count: '0,
                             match_index: '0, status: ST_EMPTY};
                done_next = 1'b1;
              end else begin
                if (req.op == OP_NEXT) begin
                  ptr_next = (ptr >= count) ? CNT_W'(1) : ptr + CNT_W'(1);
                end else if (req.op == OP_PREV) begin
                  ptr_next = (ptr <= CNT_W'(1)) ? count : ptr - CNT_W'(1);
                end
                state_next = S_FETCH;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
              ptr_next = '0;
              rsp_next = '{key_out: '0, current_index: '0, key_count: '0,
                           match_index: '0, status: ST_DONE};
              done_next = 1'b1;
            end
            default: begin
              state_next = S_FETCH;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_addr = issue_idx[ADDR_W-1:0];
        pend_next = issuing;
        pend_slot_next = issue_idx + CNT_W'(1);
        if (issuing) begin
          issue_idx_next = issue_idx + CNT_W'(1);
        end
        if (hit || !issuing) begin
          pend_next = 1'b0;
          if (op_r == OP_ADD) begin
            done_next = 1'b1;
            state_next = S_IDLE;
            if (hit) begin
              ptr_next = pend_slot;
              rsp_next = '{key_out: key_r, current_index: pend_slot, key_count: count,
                           match_index: pend_slot, status: ST_PRESENT};
            end else begin
              wr_en = 1'b1;
              ptr_next = new_slot;
              count_next = new_count;
              rsp_next = '{key_out: key_r, current_index: new_slot, key_count: new_count,
                           match_index: new_slot, status: ST_DONE};
            end
          end else begin
            match_r_next = hit ? pend_slot : '0;
            st_r_next = hit ? ST_DONE : ST_NOT_FOUND;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        rsp_next.key_out = (count == '0) ? '0 : rd_data;
        rsp_next.current_index = (count == '0) ? '0 : ptr;
        rsp_next.key_count = count;
        rsp_next.match_index = match_r;
        rsp_next.status = st_r;
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= key_r;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ptr <= '0;
      key_limit <= LIMIT_RESET;
      rsp_valid <= 1'b0;
      pend <= 1'b0;
      issue_idx <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ptr <= ptr_next;
      rsp_valid <= done_next;
      pend <= pend_next;
      issue_idx <= issue_idx_next;
      if (cfg_valid && cfg_ready) begin
        key_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_slot <= pend_slot_next;
    op_r <= op_r_next;
    key_r <= key_r_next;
    match_r <= match_r_next;
    st_r <= st_r_next;
    rsp <= rsp_next;
  end

endmodule
`default_nettype wire

// File: tb/tb_key_store_round_robin_core.sv
`timescale 1ns / 1ps

import ksrr_pkg::*;

class key_store_tracker;
  logic [KEY_W-1:0] slot_key [MAX_KEYS];
  int unsigned held;
  int unsigned ptr;
  logic [CNT_W-1:0] limit_reg;
  rsp_t pending_rsp[$];
  int unsigned mismatches;

  function new();
    held = 0;
    ptr = 0;
    limit_reg = LIMIT_RESET;
    mismatches = 0;
  endfunction

  function void set_limit(logic [CNT_W-1:0] value);
    limit_reg = value;
  endfunction

  function int unsigned find_key(logic [KEY_W-1:0] key);
    for (int unsigned s = 1; s <= held; s++) begin
      if (slot_key[s-1] == key) return s;
    end
    return 0;
  endfunction

  // Works out the response to one accepted command and queues it.
  function void note_command(req_t cmd);
    rsp_t exp_rsp;
    int unsigned lim;
    int unsigned slot;
    exp_rsp = '0;
    exp_rsp.status = ST_DONE;
    lim = limit_reg;
    if (lim < 1) lim = 1;
    if (lim > MAX_KEYS) lim = MAX_KEYS;
    case (cmd.op)
      OP_ADD: begin
        if (cmd.key_in == '0) begin
          exp_rsp.status = ST_ZERO_KEY;
        end else begin
          slot = find_key(cmd.key_in);
          if (slot != 0) begin
            ptr = slot;
            exp_rsp.match_index = CNT_W'(slot);
            exp_rsp.status = ST_PRESENT;
          end else begin
            if (held < lim) begin
              held++;
              ptr = held;
            end else begin
              ptr = (ptr >= held) ? 1 : ptr + 1;
            end
            slot_key[ptr-1] = cmd.key_in;
            exp_rsp.match_index = CNT_W'(ptr);
          end
        end
      end
      OP_LOOKUP: begin
        slot = (cmd.key_in == '0) ? 0 : find_key(cmd.key_in);
        if (slot != 0) exp_rsp.match_index = CNT_W'(slot);
        else exp_rsp.status = ST_NOT_FOUND;
      end
      OP_NEXT: begin
        if (held == 0) exp_rsp.status = ST_EMPTY;
        else ptr = (ptr >= held) ? 1 : ptr + 1;
      end
      OP_PREV: begin
        if (held == 0) exp_rsp.status = ST_EMPTY;
        else ptr = (ptr <= 1) ? held : ptr - 1;
      end
      OP_READ: begin
        if (held == 0) exp_rsp.status = ST_EMPTY;
      end
      OP_CLEAR: begin
        held = 0;
        ptr = 0;
      end
      default: begin
      end
    endcase
    exp_rsp.key_out = (held == 0) ? '0 : slot_key[ptr-1];
    exp_rsp.current_index = (held == 0) ? '0 : CNT_W'(ptr);
    exp_rsp.key_count = CNT_W'(held);
    pending_rsp.push_back(exp_rsp);
  endfunction

  function void check_response(rsp_t got);
    rsp_t exp_rsp;
    if (pending_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected response: key=%h cur=%0d cnt=%0d match=%0d status=%0d",
                 got.key_out, got.current_index, got.key_count, got.match_index, got.status);
      return;
    end
    exp_rsp = pending_rsp.pop_front();
    if (got.key_out !== exp_rsp.key_out || got.current_index !== exp_rsp.current_index ||
        got.key_count !== exp_rsp.key_count || got.match_index !== exp_rsp.match_index ||
        got.status !== exp_rsp.status) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch exp: key=%h cur=%0d cnt=%0d match=%0d status=%0d",
                 exp_rsp.key_out, exp_rsp.current_index, exp_rsp.key_count,
                 exp_rsp.match_index, exp_rsp.status);
        $display("         got: key=%h cur=%0d cnt=%0d match=%0d status=%0d",
                 got.key_out, got.current_index, got.key_count, got.match_index, got.status);
      end
    end
  endfunction
endclass

module tb_key_store_round_robin_core;

  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_ONE = KEY_W'(1);
  localparam logic [KEY_W-1:0] KEY_MSB = {1'b1, {(KEY_W-1){1'b0}}};

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic rsp_valid;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [5:0] cfg_data;

  key_store_tracker tracker;
  int unsigned burst_left;
  logic [KEY_W-1:0] key_history[$];

  key_store_round_robin_core u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_key_store_round_robin_core: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid) tracker.check_response(rsp);
  end

  task automatic idle_cycles(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Holds the command until a transfer happens; start stays high on return.
  task automatic send_command(req_t cmd);
    @(negedge clk);
    start <= 1'b1;
    req <= cmd;
    do @(posedge clk); while (busy);
    tracker.note_command(cmd);
  endtask

  task automatic issue(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    req_t cmd;
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 12));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    cmd.op = op;
    cmd.key_in = key;
    if (op == OP_ADD && key != '0) begin
      key_history.push_back(key);
      if (key_history.size() > 64) void'(key_history.pop_front());
    end
    send_command(cmd);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [5:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_limit(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] word;
    word = {$urandom(), $urandom()};
    return word[KEY_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int unsigned reuse_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < reuse_pct && tracker.held > 0)
      return tracker.slot_key[$urandom_range(1, tracker.held) - 1];
    if (roll < reuse_pct + 10 && key_history.size() > 0)
      return key_history[$urandom_range(0, key_history.size() - 1)];
    if (roll < reuse_pct + 14) return '0;
    if (roll < reuse_pct + 18) begin
      case ($urandom_range(0, 2))
        0: return KEY_ONES;
        1: return KEY_ONE;
        default: return KEY_MSB;
      endcase
    end
    return random_key();
  endfunction

  task automatic random_command(bit fill);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (fill) begin
      if (roll < 70) issue(OP_ADD, pick_key(20));
      else if (roll < 85) issue(OP_LOOKUP, pick_key(60));
      else if (roll < 92) issue(OP_NEXT, random_key());
      else issue(OP_PREV, random_key());
    end else begin
      if (roll < 40) issue(OP_ADD, pick_key(40));
      else if (roll < 60) issue(OP_LOOKUP, pick_key(60));
      else if (roll < 70) issue(OP_NEXT, random_key());
      else if (roll < 80) issue(OP_PREV, random_key());
      else if (roll < 90) issue(OP_READ, random_key());
      else if (roll < 93) issue(OP_CLEAR, random_key());
      else if (roll < 96) issue($urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7, random_key());
      else issue(OP_ADD, pick_key(0));
    end
  endtask

  initial begin
    logic [5:0] limits [9];
    tracker = new();
    burst_left = 0;
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(OP_READ, '0);
    issue(OP_NEXT, KEY_ONES);
    issue(OP_PREV, '0);
    issue(OP_LOOKUP, KEY_ONES);
    issue(OP_ADD, '0);
    issue(OP_ADD, KEY_ONES);
    issue(OP_ADD, KEY_ONE);
    issue(OP_ADD, KEY_MSB);
    issue(OP_ADD, KEY_ONES);
    issue(OP_LOOKUP, KEY_ONE);
    issue(OP_LOOKUP, '0);
    issue(OP_LOOKUP, 40'h5A5A5A5A5A);
    issue(OP_NEXT, '0);
    issue(OP_NEXT, '0);
    issue(OP_NEXT, '0);
    issue(OP_PREV, '0);
    issue(OP_PREV, '0);
    issue(OP_READ, KEY_ONES);
    issue(OP_UNUSED_6, KEY_ONES);
    issue(OP_UNUSED_7, '0);
    issue(OP_CLEAR, '0);
    issue(OP_READ, '0);
    issue(OP_ADD, 40'hA5A5A5A5A5);
    drain();

    limits = '{6'd32, 6'd5, 6'd0, 6'd63, 6'd1, 6'd2, 6'd33, 6'd20, 6'($urandom_range(0, 63))};
    for (int p = 0; p < 9; p++) begin
      write_limit(limits[p]);
      for (int i = 0; i < 80; i++) begin
        random_command(p == 0);
        if ($urandom_range(0, 59) == 0) drain();
      end
      drain();
    end

    while (tracker.pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0) begin
      $display("tb_key_store_round_robin_core: PASS");
    end else begin
      $display("tb_key_store_round_robin_core: FAIL");
    end
    $finish;
  end

endmodule
